// ===== design/dfae_pkg.sv =====
// Package: phase codes, result type and constants of the DNS A-record extractor.
package dfae_pkg;

    typedef enum logic [8:0] {
        PH_HEADER = 9'b0_0000_0001,
        PH_QNAME  = 9'b0_0000_0010,
        PH_QPTR   = 9'b0_0000_0100,
        PH_QTAIL  = 9'b0_0000_1000,
        PH_ANAME  = 9'b0_0001_0000,
        PH_APTR   = 9'b0_0010_0000,
        PH_FIXED  = 9'b0_0100_0000,
        PH_RDATA  = 9'b0_1000_0000,
        PH_DONE   = 9'b1_0000_0000
    } t_phase;

    typedef struct packed {
        logic        found;
        logic [31:0] ipv4_address;
        logic        truncated;
    } t_result;

    localparam logic [7:0]  PTR_MARK     = 8'hC0;
    localparam logic [15:0] A_LENGTH     = 16'd4;
    localparam logic [15:0] TYPE_A       = 16'd1;
    localparam logic [15:0] HDR_LAST     = 16'd11;
    localparam logic [15:0] ANCOUNT_HI   = 16'd6;
    localparam logic [15:0] ANCOUNT_LO   = 16'd7;
    localparam logic [15:0] QTAIL_LAST   = 16'd3;
    localparam logic [15:0] TYPE_HI      = 16'd0;
    localparam logic [15:0] TYPE_LO      = 16'd1;
    localparam logic [15:0] RDLEN_HI     = 16'd8;
    localparam logic [15:0] FIXED_LAST   = 16'd9;

endpackage

// ===== design/dfae_if.sv =====
// Handshake interfaces for message bytes in and extraction results out.
interface dfae_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       end_of_msg;

    modport source (output valid, output msg_byte, output end_of_msg, input ready);
    modport sink   (input valid, input msg_byte, input end_of_msg, output ready);
endinterface

interface dfae_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] ipv4_address;
    logic        truncated;

    modport source (output valid, output found, output ipv4_address, output truncated,
                    input ready);
    modport sink   (input valid, input found, input ipv4_address, input truncated,
                    output ready);
endinterface

// ===== design/dfae_parser.sv =====
// Parser state and per-byte next-state logic; forms the result on the last byte.
module dfae_parser
    import dfae_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_result    o_result
);

    t_phase      r_phase,  n_phase,  s_phase;
    logic [15:0] r_count,  n_count,  s_count;
    logic [15:0] r_answers, n_answers, s_answers;
    logic [7:0]  r_label,  n_label,  s_label;
    logic [15:0] r_type,   n_type,   s_type;
    logic [15:0] r_rdlen,  n_rdlen,  s_rdlen;
    logic [31:0] r_addr,   n_addr,   s_addr;
    logic        r_found,  n_found,  s_found;

    logic        v_is_a;
    logic [15:0] v_ans_dec;
    logic [15:0] v_cnt_inc;
    t_phase      v_ptr_phase;
    t_phase      v_after_phase;

    always_comb begin
        s_phase   = r_phase;
        s_count   = r_count;
        s_answers = r_answers;
        s_label   = r_label;
        s_type    = r_type;
        s_rdlen   = r_rdlen;
        s_addr    = r_addr;
        s_found   = r_found;

        v_is_a        = (r_type == TYPE_A) && (r_rdlen == A_LENGTH);
        v_ans_dec     = r_answers - 16'd1;
        v_cnt_inc     = r_count + 16'd1;
        v_ptr_phase   = (r_phase == PH_QNAME) ? PH_QPTR : PH_APTR;
        v_after_phase = (r_phase == PH_QNAME) ? PH_QTAIL : PH_FIXED;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_count == ANCOUNT_HI) begin
                    s_answers = {i_byte, 8'h00};
                end else if (r_count == ANCOUNT_LO) begin
                    s_answers = {r_answers[15:8], i_byte};
                end
                if (r_count >= HDR_LAST) begin
                    s_phase = PH_QNAME;
                    s_count = '0;
                    s_label = '0;
                end else begin
                    s_count = v_cnt_inc;
                end
            end
            PH_QNAME, PH_ANAME: begin
                if (r_label != 8'd0) begin
                    s_label = r_label - 8'd1;
                end else if (i_byte == 8'd0) begin
                    s_phase = v_after_phase;
                    s_count = '0;
                end else if ((i_byte & PTR_MARK) == PTR_MARK) begin
                    s_phase = v_ptr_phase;
                end else begin
                    s_label = i_byte;
                end
            end
            PH_QPTR: begin
                s_phase = PH_QTAIL;
                s_count = '0;
            end
            PH_APTR: begin
                s_phase = PH_FIXED;
                s_count = '0;
            end
            PH_QTAIL: begin
                if (r_count >= QTAIL_LAST) begin
                    s_phase = (r_answers == 16'd0) ? PH_DONE : PH_ANAME;
                    s_label = '0;
                end else begin
                    s_count = v_cnt_inc;
                end
            end
            PH_FIXED: begin
                if (r_count == TYPE_HI) begin
                    s_type = {i_byte, 8'h00};
                end else if (r_count == TYPE_LO) begin
                    s_type = {r_type[15:8], i_byte};
                end else if (r_count == RDLEN_HI) begin
                    s_rdlen = {i_byte, 8'h00};
                end else if (r_count == FIXED_LAST) begin
                    s_rdlen = {r_rdlen[15:8], i_byte};
                end
                if (r_count >= FIXED_LAST) begin
                    s_count = '0;
                    s_addr  = '0;
                    if (s_rdlen == 16'd0) begin
                        s_answers = v_ans_dec;
                        s_phase   = (v_ans_dec == 16'd0) ? PH_DONE : PH_ANAME;
                        s_label   = '0;
                    end else begin
                        s_phase = PH_RDATA;
                    end
                end else begin
                    s_count = v_cnt_inc;
                end
            end
            PH_RDATA: begin
                if (v_is_a) begin
                    s_addr = {r_addr[23:0], i_byte};
                end
                s_count = v_cnt_inc;
                if (v_cnt_inc >= r_rdlen) begin
                    if (v_is_a) begin
                        s_found = 1'b1;
                        s_phase = PH_DONE;
                    end else begin
                        s_answers = v_ans_dec;
                        s_phase   = (v_ans_dec == 16'd0) ? PH_DONE : PH_ANAME;
                        s_label   = '0;
                    end
                end
            end
            default: begin
            end
        endcase

        o_result.found        = s_found;
        o_result.ipv4_address = s_found ? s_addr : 32'd0;
        o_result.truncated    = (s_phase != PH_DONE);

        if (!i_step) begin
            n_phase   = r_phase;
            n_count   = r_count;
            n_answers = r_answers;
            n_label   = r_label;
            n_type    = r_type;
            n_rdlen   = r_rdlen;
            n_addr    = r_addr;
            n_found   = r_found;
        end else if (i_last) begin
            n_phase   = PH_HEADER;
            n_count   = '0;
            n_answers = '0;
            n_label   = '0;
            n_type    = '0;
            n_rdlen   = '0;
            n_addr    = '0;
            n_found   = 1'b0;
        end else begin
            n_phase   = s_phase;
            n_count   = s_count;
            n_answers = s_answers;
            n_label   = s_label;
            n_type    = s_type;
            n_rdlen   = s_rdlen;
            n_addr    = s_addr;
            n_found   = s_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_count   <= '0;
            r_answers <= '0;
            r_label   <= '0;
            r_type    <= '0;
            r_rdlen   <= '0;
            r_addr    <= '0;
            r_found   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_answers <= n_answers;
            r_label   <= n_label;
            r_type    <= n_type;
            r_rdlen   <= n_rdlen;
            r_addr    <= n_addr;
            r_found   <= n_found;
        end
    end

endmodule

// ===== design/dfae_out_reg.sv =====
// Result register driving the output channel.
module dfae_out_reg
    import dfae_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_result,
    output logic        o_free,
    dfae_out_if.source  o_res
);

    logic    r_valid, n_valid;
    t_result r_data;

    assign o_free = !r_valid || o_res.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_res.ready) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.found        = r_data.found;
    assign o_res.ipv4_address = r_data.ipv4_address;
    assign o_res.truncated    = r_data.truncated;

endmodule

// ===== design/dns_first_a_record_extractor_unit.sv =====
// Top level: input byte register, parser and result register.
// Output: the result register loads when a last-byte beat leaves the input register.
// Throughput: one byte beat per cycle; the input register stalls only when a
// last-byte beat meets a full result register that is not being drained.
// Reset: synchronous, active low; clears the handshake valids and returns the
// parser to the header phase with all counts and captured fields at zero.
module dns_first_a_record_extractor_unit
    import dfae_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dfae_in_if.sink    i_msg,
    dfae_out_if.source o_res
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       w_free;
    logic       w_fire;
    t_result    w_result;

    assign w_fire      = r_in_valid && (!r_last || w_free);
    assign i_msg.ready = !r_in_valid || w_fire;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_fire) begin
            n_in_valid = 1'b0;
        end
        if (i_msg.valid && i_msg.ready) begin
            n_in_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_msg.valid && i_msg.ready) begin
            r_byte <= i_msg.msg_byte;
            r_last <= i_msg.end_of_msg;
        end
    end

    dfae_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_fire),
        .i_byte   (r_byte),
        .i_last   (r_last),
        .o_result (w_result)
    );

    dfae_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire && r_last),
        .i_result (w_result),
        .o_free   (w_free),
        .o_res    (o_res)
    );

endmodule

// ===== dv/dfae_answer_check.sv =====
`timescale 1ns / 1ps
// Checker: predicts the A-record result of each datagram from accepted bytes and compares.
module dfae_answer_check
    import dfae_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    dfae_in_if   i_msg_mon,
    dfae_out_if  i_res_mon,
    output int   o_mismatch_count,
    output int   o_pending
);

    t_phase      phase_q;
    logic [15:0] field_cnt;
    logic [15:0] answers_left;
    logic [7:0]  label_left;
    logic [15:0] rec_type;
    logic [15:0] rec_len;
    logic [31:0] addr_acc;
    logic        found_q;
    t_result     expected_results[$];
    int          mismatches;

    function automatic void clear_parser();
        phase_q      = PH_HEADER;
        field_cnt    = '0;
        answers_left = '0;
        label_left   = '0;
        rec_type     = '0;
        rec_len      = '0;
        addr_acc     = '0;
        found_q      = 1'b0;
    endfunction

    function automatic void begin_answers();
        phase_q    = (answers_left == 16'd0) ? PH_DONE : PH_ANAME;
        label_left = '0;
    endfunction

    function automatic void close_record();
        answers_left = answers_left - 16'd1;
        begin_answers();
    endfunction

    function automatic void name_step(input logic [7:0] b, input t_phase ptr_ph,
                                      input t_phase after_ph);
        if (label_left != 8'd0) begin
            label_left = label_left - 8'd1;
        end else if (b == 8'h00) begin
            phase_q   = after_ph;
            field_cnt = '0;
        end else if ((b & PTR_MARK) == PTR_MARK) begin
            phase_q = ptr_ph;
        end else begin
            label_left = b;
        end
    endfunction

    function automatic logic is_a_record();
        return (rec_type == TYPE_A) && (rec_len == A_LENGTH);
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic last);
        t_result r;
        case (phase_q)
            PH_HEADER: begin
                if (field_cnt == ANCOUNT_HI) answers_left = {b, 8'h00};
                else if (field_cnt == ANCOUNT_LO) answers_left = answers_left | {8'h00, b};
                if (field_cnt >= HDR_LAST) begin
                    phase_q    = PH_QNAME;
                    field_cnt  = '0;
                    label_left = '0;
                end else begin
                    field_cnt = field_cnt + 16'd1;
                end
            end
            PH_QNAME: name_step(b, PH_QPTR, PH_QTAIL);
            PH_QPTR: begin
                phase_q   = PH_QTAIL;
                field_cnt = '0;
            end
            PH_QTAIL: begin
                if (field_cnt >= QTAIL_LAST) begin_answers();
                else field_cnt = field_cnt + 16'd1;
            end
            PH_ANAME: name_step(b, PH_APTR, PH_FIXED);
            PH_APTR: begin
                phase_q   = PH_FIXED;
                field_cnt = '0;
            end
            PH_FIXED: begin
                if (field_cnt == TYPE_HI) rec_type = {b, 8'h00};
                else if (field_cnt == TYPE_LO) rec_type = rec_type | {8'h00, b};
                else if (field_cnt == RDLEN_HI) rec_len = {b, 8'h00};
                else if (field_cnt == FIXED_LAST) rec_len = rec_len | {8'h00, b};
                if (field_cnt >= FIXED_LAST) begin
                    field_cnt = '0;
                    addr_acc  = '0;
                    if (rec_len == 16'd0) close_record();
                    else phase_q = PH_RDATA;
                end else begin
                    field_cnt = field_cnt + 16'd1;
                end
            end
            PH_RDATA: begin
                if (is_a_record()) addr_acc = {addr_acc[23:0], b};
                field_cnt = field_cnt + 16'd1;
                if (field_cnt >= rec_len) begin
                    if (is_a_record()) begin
                        found_q = 1'b1;
                        phase_q = PH_DONE;
                    end else begin
                        close_record();
                    end
                end
            end
            default: ;
        endcase
        if (last) begin
            r.found        = found_q;
            r.ipv4_address = found_q ? addr_acc : 32'h0;
            r.truncated    = (phase_q != PH_DONE);
            expected_results.push_back(r);
            clear_parser();
        end
    endfunction

    function automatic void check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t ERROR: result with nothing pending: found=%0b addr=%08h trunc=%0b",
                         $time, i_res_mon.found, i_res_mon.ipv4_address, i_res_mon.truncated);
        end else begin
            want = expected_results.pop_front();
            if (want.found !== i_res_mon.found || want.ipv4_address !== i_res_mon.ipv4_address
                || want.truncated !== i_res_mon.truncated) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t ERROR: expected found=%0b addr=%08h trunc=%0b, got found=%0b addr=%08h trunc=%0b",
                             $time, want.found, want.ipv4_address, want.truncated,
                             i_res_mon.found, i_res_mon.ipv4_address, i_res_mon.truncated);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            expected_results.delete();
            mismatches = 0;
        end else begin
            if (i_res_mon.valid && i_res_mon.ready) check_result();
            if (i_msg_mon.valid && i_msg_mon.ready)
                parse_byte(i_msg_mon.msg_byte, i_msg_mon.end_of_msg);
        end
        o_mismatch_count <= mismatches;
        o_pending        <= expected_results.size();
    end

endmodule

// ===== dv/dns_first_a_record_extractor_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench top: streams DNS response datagrams into the extractor and reports the verdict.
module dns_first_a_record_extractor_unit_test;
    import dfae_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int BYTE_TARGET = 1550;
    localparam int MSG_TARGET  = 48;

    logic       i_clk;
    logic       i_rst_n;
    int         error_count;
    int         pending_results;
    int         bytes_sent;
    int         msgs_sent;
    bit         sender_steady;
    bit         hold_req;
    int         calm_left;
    logic [7:0] msg_buf[$];

    dfae_in_if  msg_bus ();
    dfae_out_if res_bus ();

    dns_first_a_record_extractor_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_bus),
        .o_res   (res_bus)
    );

    dfae_answer_check u_answer_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_msg_mon        (msg_bus),
        .i_res_mon        (res_bus),
        .o_mismatch_count (error_count),
        .o_pending        (pending_results)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void put_header(input logic [15:0] ancount);
        repeat (6) msg_buf.push_back(8'($urandom));
        msg_buf.push_back(ancount[15:8]);
        msg_buf.push_back(ancount[7:0]);
        repeat (4) msg_buf.push_back(8'($urandom));
    endfunction

    function automatic void put_qtail();
        repeat (4) msg_buf.push_back(8'($urandom));
    endfunction

    // type, class, ttl, rdlength, then data_len bytes of rdata
    function automatic void put_record(input logic [15:0] rtype, input logic [15:0] rdlen,
                                       input int data_len);
        msg_buf.push_back(rtype[15:8]);
        msg_buf.push_back(rtype[7:0]);
        repeat (6) msg_buf.push_back(8'($urandom));
        msg_buf.push_back(rdlen[15:8]);
        msg_buf.push_back(rdlen[7:0]);
        repeat (data_len) msg_buf.push_back(8'($urandom));
    endfunction

    function automatic void put_name();
        int         kind;
        logic [7:0] len;
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
            msg_buf.push_back(8'h00);
        end else if (kind < 6) begin
            msg_buf.push_back({2'b11, 6'($urandom)});
            msg_buf.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 2)) begin
                if ($urandom_range(0, 29) == 0)
                    len = $urandom_range(0, 1) ? (8'h40 | 8'($urandom_range(0, 3)))
                                               : (8'h80 | 8'($urandom_range(0, 3)));
                else
                    len = 8'($urandom_range(1, 5));
                msg_buf.push_back(len);
                repeat (len) msg_buf.push_back(8'($urandom));
            end
            if ($urandom_range(0, 1) == 0) begin
                msg_buf.push_back(8'h00);
            end else begin
                msg_buf.push_back({2'b11, 6'($urandom)});
                msg_buf.push_back(8'($urandom));
            end
        end
    endfunction

    function automatic void build_random_msg();
        int          n_ans;
        int          cut;
        logic [15:0] rtype;
        logic [15:0] rdlen;
        int          dlen;
        msg_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) msg_buf.push_back(8'($urandom));
            return;
        end
        n_ans = $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0) put_header(16'($urandom));
        else put_header(16'(n_ans));
        put_name();
        put_qtail();
        repeat (n_ans) begin
            put_name();
            rtype = ($urandom_range(0, 9) < 6) ? TYPE_A : 16'($urandom);
            if ($urandom_range(0, 29) == 0) begin
                rdlen = 16'($urandom);
                dlen  = 6;
            end else if (rtype == TYPE_A && $urandom_range(0, 4) != 0) begin
                rdlen = A_LENGTH;
                dlen  = 4;
            end else begin
                dlen  = $urandom_range(0, 8);
                rdlen = 16'(dlen);
            end
            put_record(rtype, rdlen, dlen);
        end
        repeat ($urandom_range(0, 3)) msg_buf.push_back(8'($urandom));
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, msg_buf.size());
            while (msg_buf.size() > cut) void'(msg_buf.pop_back());
        end
    endfunction

    task automatic send_msg();
        int gap;
        for (int i = 0; i < msg_buf.size(); i++) begin
            if (sender_steady || $urandom_range(0, 2) == 0) gap = 0;
            else gap = $urandom_range(0, 18);
            if (gap > 0) begin
                msg_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            msg_bus.valid      <= 1'b1;
            msg_bus.msg_byte   <= msg_buf[i];
            msg_bus.end_of_msg <= (i == msg_buf.size() - 1);
            @(posedge i_clk);
            while (!msg_bus.ready) @(posedge i_clk);
        end
        bytes_sent += msg_buf.size();
        msgs_sent++;
    endtask

    task automatic wait_results_drained();
        msg_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int stall;
        res_bus.ready <= 1'b0;
        calm_left = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if (calm_left > 0) begin
                stall = 0;
                calm_left--;
            end else begin
                stall = $urandom_range(0, 18);
                if ($urandom_range(0, 7) == 0) calm_left = $urandom_range(2, 8);
            end
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_bus.valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        bit pressure_done;
        i_rst_n            <= 1'b0;
        msg_bus.valid      <= 1'b0;
        msg_bus.msg_byte   <= 8'h00;
        msg_bus.end_of_msg <= 1'b0;
        sender_steady = 1'b0;
        hold_req      = 1'b0;
        pressure_done = 1'b0;
        bytes_sent    = 0;
        msgs_sent     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // header cut short
        msg_buf = {8'hFF};
        send_msg();

        // no answers, trailing bytes ignored
        msg_buf.delete();
        put_header(16'h0000);
        msg_buf = {msg_buf, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'hFF, 8'h00};
        send_msg();

        // compressed names, A record with extreme octets
        msg_buf.delete();
        put_header(16'h0001);
        msg_buf = {msg_buf, 8'hC0, 8'h0C};
        put_qtail();
        msg_buf = {msg_buf, 8'hC0, 8'h0C};
        put_record(TYPE_A, A_LENGTH, 0);
        msg_buf = {msg_buf, 8'hFF, 8'h00, 8'hFF, 8'h80};
        send_msg();

        // reserved label prefix, empty rdata, then an A record
        msg_buf.delete();
        put_header(16'h0002);
        msg_buf.push_back(8'h40);
        repeat (64) msg_buf.push_back(8'($urandom));
        msg_buf.push_back(8'h00);
        put_qtail();
        msg_buf.push_back(8'h00);
        put_record(16'd5, 16'd0, 0);
        msg_buf = {msg_buf, 8'h03, 8'h61, 8'h62, 8'h63, 8'hC0, 8'h0C};
        put_record(TYPE_A, A_LENGTH, 4);
        send_msg();

        // address cut short
        msg_buf.delete();
        put_header(16'h0001);
        msg_buf.push_back(8'h00);
        put_qtail();
        msg_buf.push_back(8'h00);
        put_record(TYPE_A, A_LENGTH, 2);
        send_msg();

        // fewer answers than announced
        msg_buf.delete();
        put_header(16'h0003);
        msg_buf.push_back(8'h00);
        put_qtail();
        msg_buf.push_back(8'h00);
        put_record(16'd16, 16'd3, 3);
        send_msg();

        // type A with wrong length, all answers walked
        msg_buf.delete();
        put_header(16'h0001);
        msg_buf.push_back(8'h00);
        put_qtail();
        msg_buf.push_back(8'h00);
        put_record(TYPE_A, 16'd5, 5);
        send_msg();

        // fixed fields cut short
        msg_buf.delete();
        put_header(16'hFFFF);
        msg_buf.push_back(8'h00);
        put_qtail();
        msg_buf = {msg_buf, 8'h00, 8'h00, 8'h01};
        send_msg();

        wait_results_drained();

        while (bytes_sent < BYTE_TARGET || msgs_sent < MSG_TARGET) begin
            if (!pressure_done && bytes_sent > BYTE_TARGET / 2) begin
                // output held off while short datagrams keep arriving back to back
                pressure_done = 1'b1;
                sender_steady = 1'b1;
                hold_req      = 1'b1;
                repeat (30) begin
                    msg_buf.delete();
                    repeat ($urandom_range(1, 2)) msg_buf.push_back(8'($urandom));
                    send_msg();
                end
                wait_results_drained();
            end
            sender_steady = ($urandom_range(0, 3) == 0);
            build_random_msg();
            send_msg();
        end

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
design/dfae_pkg.sv
design/dfae_if.sv
design/dfae_parser.sv
design/dfae_out_reg.sv
design/dns_first_a_record_extractor_unit.sv
dv/dfae_answer_check.sv
dv/dns_first_a_record_extractor_unit_test.sv
